[hw/rtl/i2cbb_pkg.sv]
// Shared constants for the bit-banged I2C master: phase codes, widths and masks.
package i2cbb_pkg;

  localparam int unsigned OpW      = 2;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned PhaseW   = 5;
  localparam int unsigned BitCntW  = 4;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;

  localparam logic [ByteW-1:0] DefaultHalfDelay = '0;

  localparam logic [OpW-1:0] OpTick  = 2'd0;
  localparam logic [OpW-1:0] OpWrite = 2'd1;
  localparam logic [OpW-1:0] OpRead  = 2'd2;

  localparam logic [BitCntW-1:0] DataBits  = 4'd8;
  localparam logic [BitCntW-1:0] FrameBits = 4'd9;

  localparam logic [PhaseW-1:0] PIdle     = 5'd0;
  localparam logic [PhaseW-1:0] PStRel    = 5'd1;
  localparam logic [PhaseW-1:0] PStD1     = 5'd2;
  localparam logic [PhaseW-1:0] PStSclUp  = 5'd3;
  localparam logic [PhaseW-1:0] PStWait   = 5'd4;
  localparam logic [PhaseW-1:0] PStD2     = 5'd5;
  localparam logic [PhaseW-1:0] PStArb    = 5'd6;
  localparam logic [PhaseW-1:0] PStD3     = 5'd7;
  localparam logic [PhaseW-1:0] PStSclDn  = 5'd8;
  localparam logic [PhaseW-1:0] PBitSet   = 5'd9;
  localparam logic [PhaseW-1:0] PBitD1    = 5'd10;
  localparam logic [PhaseW-1:0] PBitSclUp = 5'd11;
  localparam logic [PhaseW-1:0] PBitWait  = 5'd12;
  localparam logic [PhaseW-1:0] PBitD2    = 5'd13;
  localparam logic [PhaseW-1:0] PBitSmp   = 5'd14;
  localparam logic [PhaseW-1:0] PSpLow    = 5'd15;
  localparam logic [PhaseW-1:0] PSpD1     = 5'd16;
  localparam logic [PhaseW-1:0] PSpSclUp  = 5'd17;
  localparam logic [PhaseW-1:0] PSpWait   = 5'd18;
  localparam logic [PhaseW-1:0] PSpD2     = 5'd19;
  localparam logic [PhaseW-1:0] PSpSdaUp  = 5'd20;
  localparam logic [PhaseW-1:0] PSpCheck  = 5'd21;

  localparam logic [ByteW-1:0] MsbMask = 8'h80;

endpackage

[hw/rtl/i2c_bitbang_master_unit.sv]
// Bit-banged I2C master sequencer: one input word is one tick of the bus timing.
// The result word for an input word is registered when the word is accepted and appears in the next cycle.
// Throughput: one word per cycle while results are taken; the sequencer step is a single registered pass.
// A result that is not taken stalls the input only while the output register stays full.
// Reset: asynchronous, active low; phase idle, both lines released, delay register zero.
module i2c_bitbang_master_unit
  import i2cbb_pkg::*;
#(
  parameter logic [ByteW-1:0] HalfDelayReset = DefaultHalfDelay
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [ByteW-1:0]    cfg_wdata_i,    // half_delay_ticks
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: start_req, stop_req, tx_byte[7:0], scl_in, sda_in, zero fill
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic [OpW-1:0]      s_axis_tuser,   // op
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: scl_release, sda_release, busy_res, done_res, rx_byte[7:0], nack, arb_lost, zero fill
  output logic [OutDataW-1:0] m_axis_tdata
);

  logic [ByteW-1:0]   half_q;
  logic [PhaseW-1:0]  phase_q, phase_d;
  logic [BitCntW-1:0] bit_cnt_q, bit_cnt_d;
  logic [ByteW-1:0]   shift_q, shift_d;
  logic [ByteW-1:0]   delay_q, delay_d;
  logic               started_q, started_d;
  logic               scl_out_q, scl_out_d;
  logic               sda_out_q, sda_out_d;
  logic               pend_stop_q, pend_stop_d;
  logic               is_read_q, is_read_d;
  logic               nack_q, nack_d;
  logic               arb_q, arb_d;
  logic               done;
  logic               out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic           in_fire;
  logic [OpW-1:0] in_op;
  logic           in_start, in_stop, in_scl, in_sda;
  logic [ByteW-1:0] in_tx;

  assign in_op    = s_axis_tuser;
  assign in_start = s_axis_tdata[0];
  assign in_stop  = s_axis_tdata[1];
  assign in_tx    = s_axis_tdata[9:2];
  assign in_scl   = s_axis_tdata[10];
  assign in_sda   = s_axis_tdata[11];

  // The output register frees up in the same cycle it is drained.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    phase_d     = phase_q;
    bit_cnt_d   = bit_cnt_q;
    shift_d     = shift_q;
    delay_d     = delay_q;
    started_d   = started_q;
    scl_out_d   = scl_out_q;
    sda_out_d   = sda_out_q;
    pend_stop_d = pend_stop_q;
    is_read_d   = is_read_q;
    nack_d      = nack_q;
    arb_d       = arb_q;
    done        = 1'b0;

    case (phase_q)
      PIdle: begin
        if (in_op == OpWrite || in_op == OpRead) begin
          is_read_d   = (in_op == OpRead);
          pend_stop_d = in_stop;
          bit_cnt_d   = '0;
          arb_d       = 1'b0;
          shift_d     = (in_op == OpRead) ? '0 : in_tx;
          phase_d     = (in_op == OpWrite && in_start) ? PStRel : PBitSet;
        end
      end
      PStRel: begin
        if (started_q) begin
          sda_out_d = 1'b1;
          delay_d   = half_q;
          phase_d   = PStD1;
        end else begin
          phase_d = PStArb;
        end
      end
      PStD1: begin
        if (delay_q == '0) phase_d = PStSclUp;
        else delay_d = delay_q - 1'b1;
      end
      PStSclUp: begin
        scl_out_d = 1'b1;
        phase_d   = PStWait;
      end
      PStWait: begin
        if (in_scl) begin
          delay_d = half_q;
          phase_d = PStD2;
        end
      end
      PStD2: begin
        if (delay_q == '0) phase_d = PStArb;
        else delay_d = delay_q - 1'b1;
      end
      PStArb: begin
        if (!in_sda) arb_d = 1'b1;
        sda_out_d = 1'b0;
        delay_d   = half_q;
        phase_d   = PStD3;
      end
      PStD3: begin
        if (delay_q == '0) phase_d = PStSclDn;
        else delay_d = delay_q - 1'b1;
      end
      PStSclDn: begin
        scl_out_d = 1'b0;
        started_d = 1'b1;
        phase_d   = PBitSet;
      end
      PBitSet: begin
        if (is_read_q || bit_cnt_q >= DataBits) sda_out_d = 1'b1;
        else sda_out_d = (shift_q & MsbMask) != '0;
        delay_d = half_q;
        phase_d = PBitD1;
      end
      PBitD1: begin
        if (delay_q == '0) phase_d = PBitSclUp;
        else delay_d = delay_q - 1'b1;
      end
      PBitSclUp: begin
        scl_out_d = 1'b1;
        phase_d   = PBitWait;
      end
      PBitWait: begin
        if (in_scl) begin
          if (!is_read_q && bit_cnt_q < DataBits) begin
            // Write data bits drop SCL as soon as the high level is seen.
            if (sda_out_q && !in_sda) arb_d = 1'b1;
            shift_d   = {shift_q[ByteW-2:0], 1'b0};
            scl_out_d = 1'b0;
            bit_cnt_d = bit_cnt_q + 1'b1;
            if (bit_cnt_d >= FrameBits) begin
              phase_d = pend_stop_q ? PSpLow : PIdle;
              done    = !pend_stop_q;
            end else begin
              phase_d = PBitSet;
            end
          end else begin
            delay_d = half_q;
            phase_d = PBitD2;
          end
        end
      end
      PBitD2: begin
        if (delay_q == '0) phase_d = PBitSmp;
        else delay_d = delay_q - 1'b1;
      end
      PBitSmp: begin
        if (bit_cnt_q < DataBits) shift_d = {shift_q[ByteW-2:0], in_sda};
        else nack_d = in_sda;
        scl_out_d = 1'b0;
        bit_cnt_d = bit_cnt_q + 1'b1;
        if (bit_cnt_d >= FrameBits) begin
          phase_d = pend_stop_q ? PSpLow : PIdle;
          done    = !pend_stop_q;
        end else begin
          phase_d = PBitSet;
        end
      end
      PSpLow: begin
        sda_out_d = 1'b0;
        delay_d   = half_q;
        phase_d   = PSpD1;
      end
      PSpD1: begin
        if (delay_q == '0) phase_d = PSpSclUp;
        else delay_d = delay_q - 1'b1;
      end
      PSpSclUp: begin
        scl_out_d = 1'b1;
        phase_d   = PSpWait;
      end
      PSpWait: begin
        if (in_scl) begin
          delay_d = half_q;
          phase_d = PSpD2;
        end
      end
      PSpD2: begin
        if (delay_q == '0) phase_d = PSpSdaUp;
        else delay_d = delay_q - 1'b1;
      end
      PSpSdaUp: begin
        sda_out_d = 1'b1;
        phase_d   = PSpCheck;
      end
      PSpCheck: begin
        // SDA was released last tick; a low level now means another master holds it.
        if (!in_sda) arb_d = 1'b1;
        started_d = 1'b0;
        phase_d   = PIdle;
        done      = 1'b1;
      end
      default: begin
        phase_d = PIdle;
      end
    endcase

    out_data_d = {2'b00, arb_d, nack_d, (is_read_d ? shift_d : {ByteW{1'b0}}), done,
                  (phase_d != PIdle), sda_out_d, scl_out_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= HalfDelayReset;
    end else if (cfg_we_i) begin
      half_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PIdle;
      bit_cnt_q   <= '0;
      shift_q     <= '0;
      delay_q     <= '0;
      started_q   <= 1'b0;
      scl_out_q   <= 1'b1;
      sda_out_q   <= 1'b1;
      pend_stop_q <= 1'b0;
      is_read_q   <= 1'b0;
      nack_q      <= 1'b0;
      arb_q       <= 1'b0;
    end else if (in_fire) begin
      phase_q     <= phase_d;
      bit_cnt_q   <= bit_cnt_d;
      shift_q     <= shift_d;
      delay_q     <= delay_d;
      started_q   <= started_d;
      scl_out_q   <= scl_out_d;
      sda_out_q   <= sda_out_d;
      pend_stop_q <= pend_stop_d;
      is_read_q   <= is_read_d;
      nack_q      <= nack_d;
      arb_q       <= arb_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while the result register is stalled");

  a_busy_matches_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (m_axis_tdata[2] == (phase_q != PIdle)))
    else $error("busy bit disagrees with the sequencer phase");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[3]) |-> !m_axis_tdata[2])
    else $error("done reported while still busy");

  a_rx_zero_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !is_read_q) |-> (m_axis_tdata[11:4] == '0))
    else $error("received byte nonzero after a write command");

endmodule
